@@ design/srs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package srs_pkg;

  localparam int ScriptW = 8;
  localparam int StartW  = 16;
  localparam int LengthW = 17;

  // Configuration register indexes
  localparam logic [1:0] CFG_COMMON  = 2'd0;
  localparam logic [1:0] CFG_UNKNOWN = 2'd1;
  localparam logic [1:0] CFG_LATIN   = 2'd2;

  localparam logic [ScriptW-1:0] CommonReset  = 8'd0;
  localparam logic [ScriptW-1:0] UnknownReset = 8'd255;
  localparam logic [ScriptW-1:0] LatinReset   = 8'd1;

  // Result queue: two words may enter per item
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;
  localparam int QueueCntW  = 3;

  typedef struct packed {
    logic [ScriptW-1:0] char_script;
    logic               new_paragraph;
    logic               script_is_rtl;
    logic               last_char;
  } in_item_t;

  typedef struct packed {
    logic [StartW-1:0]  out_start;
    logic [LengthW-1:0] out_length;
    logic [ScriptW-1:0] out_script;
    logic               out_final;
  } out_item_t;

  typedef struct packed {
    logic first;   // push one word
    logic second;  // push a second word behind it
  } push_t;

endpackage

`default_nettype wire

@@ design/script_run_segmenter.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Word
// in        input      in_valid / in_stall   in_item_t: one classified character
// out       output     out_valid / out_stall out_item_t: one script run
// cfg       input      cfg_we (no wait)      cfg_index / cfg_data
//
// One character per cycle while the queue has room; it waits in the input
// register until the step queues its runs, which leave one word per cycle.
// A character starts its step only when the four-word result queue has two
// free slots, so the queue sets the rate under a stalled output.
// Synchronous reset clears the run state and loads the register defaults.

module script_run_segmenter #(
  parameter int MAX_CHARS = 65536
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire srs_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output srs_pkg::out_item_t       out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [7:0]          cfg_data
);
  import srs_pkg::*;

  in_item_t   item;
  logic       item_vld;
  logic       room;
  logic       go;
  push_t      push;
  out_item_t  res0;
  out_item_t  res1;

  assign go       = item_vld && room;
  assign in_stall = item_vld && !room;

  // Input register: hold the word until the step takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (!in_stall) begin
      item_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) item <= in_data;
  end

  srs_step #(
    .MAX_CHARS(MAX_CHARS)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .go        (go),
    .item      (item),
    .push      (push),
    .res0      (res0),
    .res1      (res1)
  );

  srs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ design/srs_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srs_step #(
  parameter int MAX_CHARS = 65536
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [7:0]          cfg_data,
  input  wire logic                go,
  input  wire srs_pkg::in_item_t   item,
  output srs_pkg::push_t           push,
  output srs_pkg::out_item_t       res0,
  output srs_pkg::out_item_t       res1
);
  import srs_pkg::*;

  localparam int CW = $clog2(MAX_CHARS + 1);
  localparam logic [CW:0]   MaxC   = (CW+1)'(MAX_CHARS);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_CHARS);
  localparam logic [CW-1:0] MaxBeg = CW'(MAX_CHARS - 1);
  localparam logic [CW-1:0] One    = CW'(1);

  logic [ScriptW-1:0] common_code;
  logic [ScriptW-1:0] unknown_code;
  logic [ScriptW-1:0] latin_code;

  logic [CW-1:0]      run_begin, run_begin_next;
  logic [CW-1:0]      run_count, run_count_next;
  logic [ScriptW-1:0] run_code, run_code_next;
  logic               run_rtl, run_rtl_next;
  logic [CW-1:0]      pending_common, pending_common_next;
  logic               await_first_script, await_first_script_next;
  logic               paragraph_rtl, paragraph_rtl_next;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > MaxC) ? MaxCnt : s[CW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      common_code  <= CommonReset;
      unknown_code <= UnknownReset;
      latin_code   <= LatinReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COMMON:  common_code  <= cfg_data;
        CFG_UNKNOWN: unknown_code <= cfg_data;
        CFG_LATIN:   latin_code   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic               is_common;
    logic               emit_change;
    logic [CW:0]        bsum;
    logic [ScriptW-1:0] fcode;
    logic [CW-1:0]      chg_begin;
    logic [CW-1:0]      chg_count;
    logic [ScriptW-1:0] chg_code;

    run_begin_next          = run_begin;
    run_count_next          = run_count;
    run_code_next           = run_code;
    run_rtl_next            = run_rtl;
    pending_common_next     = pending_common;
    await_first_script_next = await_first_script;
    paragraph_rtl_next      = paragraph_rtl;
    emit_change             = 1'b0;
    chg_begin               = run_begin;
    chg_count               = run_count;
    chg_code                = run_code;
    bsum                    = '0;
    fcode                   = run_code;
    is_common               = (item.char_script == common_code);

    if (is_common) begin
      pending_common_next = sat_add(pending_common, One);
      if (item.new_paragraph) begin
        await_first_script_next = 1'b1;
        if (run_code != unknown_code) begin
          run_count_next      = sat_add(run_count, pending_common_next);
          pending_common_next = '0;
        end
      end
    end else begin
      if (await_first_script && item.char_script != unknown_code) begin
        paragraph_rtl_next      = item.script_is_rtl;
        await_first_script_next = 1'b0;
      end
      if (item.char_script != run_code) begin
        // Pending commons join a known closing run when directions agree
        if (run_code != unknown_code &&
            (paragraph_rtl_next == run_rtl || run_rtl == item.script_is_rtl)) begin
          run_count_next      = sat_add(run_count, pending_common);
          pending_common_next = '0;
        end
        emit_change = (run_count_next != '0);
        chg_count   = run_count_next;
        bsum        = {1'b0, run_begin} + {1'b0, run_count_next};
        run_begin_next      = (bsum > {1'b0, MaxBeg}) ? MaxBeg : bsum[CW-1:0];
        run_count_next      = sat_add(pending_common_next, One);
        run_code_next       = item.char_script;
        run_rtl_next        = item.script_is_rtl;
        pending_common_next = '0;
      end else begin
        if (run_code != unknown_code) begin
          run_count_next      = sat_add(run_count, pending_common);
          pending_common_next = '0;
        end
        run_count_next = sat_add(run_count_next, One);
      end
    end

    fcode = (run_code_next == unknown_code) ? latin_code : run_code_next;
    res1.out_start  = StartW'(run_begin_next);
    res1.out_length = LengthW'(sat_add(run_count_next, pending_common_next));
    res1.out_script = fcode;
    res1.out_final  = 1'b1;

    if (emit_change) begin
      res0.out_start  = StartW'(chg_begin);
      res0.out_length = LengthW'(chg_count);
      res0.out_script = chg_code;
      res0.out_final  = 1'b0;
    end else begin
      res0 = res1;
    end

    push.first  = go && (emit_change || item.last_char);
    push.second = go && emit_change && item.last_char;

    if (item.last_char) begin
      run_begin_next          = '0;
      run_count_next          = '0;
      run_code_next           = unknown_code;
      run_rtl_next            = 1'b0;
      pending_common_next     = '0;
      await_first_script_next = 1'b1;
      paragraph_rtl_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_begin          <= '0;
      run_count          <= '0;
      run_code           <= UnknownReset;
      run_rtl            <= 1'b0;
      pending_common     <= '0;
      await_first_script <= 1'b1;
      paragraph_rtl      <= 1'b0;
    end else if (go) begin
      run_begin          <= run_begin_next;
      run_count          <= run_count_next;
      run_code           <= run_code_next;
      run_rtl            <= run_rtl_next;
      pending_common     <= pending_common_next;
      await_first_script <= await_first_script_next;
      paragraph_rtl      <= paragraph_rtl_next;
    end
  end

endmodule

`default_nettype wire

@@ design/srs_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srs_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire srs_pkg::push_t      push,
  input  wire srs_pkg::out_item_t  res0,
  input  wire srs_pkg::out_item_t  res1,
  output logic                     room,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output srs_pkg::out_item_t       out_data
);
  import srs_pkg::*;

  out_item_t             mem [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr;
  logic [QueuePtrW-1:0]  rd_ptr;
  logic [QueueCntW-1:0]  count;
  logic                  pop;
  logic [QueueCntW-1:0]  n_push;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  // Two free slots cover the worst item
  assign room      = (count <= QueueCntW'(QueueDepth - 2));
  assign n_push    = QueueCntW'(push.first) + QueueCntW'(push.second);

  always_ff @(posedge clk) begin
    if (push.first) mem[wr_ptr] <= res0;
    if (push.second) mem[wr_ptr + QueuePtrW'(1)] <= res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[QueuePtrW-1:0];
      if (pop) rd_ptr <= rd_ptr + QueuePtrW'(1);
      count <= count + n_push - QueueCntW'(pop);
    end
  end

endmodule

`default_nettype wire
